[rtl/running_mean_variance_macros.svh]
// ----------------------------------------------------------------------------
// Running mean and variance: assertion macros
// Shorthand for clocked assertions that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rmv_pkg.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: package
// Shared widths, constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package rmv_pkg;

    localparam int VAR_WIDTH = 48;
    localparam int VAR_FRAC  = 16;
    localparam int SQ_IN_W   = 32;
    localparam int SQ_W      = 2 * SQ_IN_W;

    localparam logic [VAR_WIDTH-1:0] VAR_MAX = {VAR_WIDTH{1'b1}};

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_var;
        logic take_q;
        logic square;
        logic mul_start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic n_ge2;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/rmv_div.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: radix-2 divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_div #(
    parameter int DIVIDEND_WIDTH = 48,
    parameter int DIVISOR_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVIDEND_WIDTH-1:0] i_dividend,
    input  logic [DIVISOR_WIDTH-1:0]  i_divisor,
    output logic                      o_busy,
    output logic [DIVIDEND_WIDTH-1:0] o_quotient,
    output logic [DIVISOR_WIDTH-1:0]  o_remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH + 1);

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [DIVIDEND_WIDTH-1:0] r_quo;
    logic [DIVISOR_WIDTH-1:0]  r_rem;
    logic [DIVISOR_WIDTH-1:0]  r_dvs;
    logic [DIVISOR_WIDTH-1:0]  n_rem;
    logic [DIVISOR_WIDTH:0]    w_trial;
    logic [DIVISOR_WIDTH:0]    w_diff;
    logic                      w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DIVIDEND_WIDTH-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DIVISOR_WIDTH-1:0] : w_trial[DIVISOR_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_WIDTH-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[rtl/rmv_mul.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle from the top, with a
// sticky flag for products that leave the accumulator width.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_mul #(
    parameter int MCAND_WIDTH = 64,
    parameter int MPLR_WIDTH  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [MCAND_WIDTH-1:0] i_mcand,
    input  logic [MPLR_WIDTH-1:0]  i_mplr,
    output logic                   o_busy,
    output logic [MCAND_WIDTH-1:0] o_product,
    output logic                   o_overflow
);

    localparam int CNT_W = $clog2(MPLR_WIDTH + 1);

    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic [MCAND_WIDTH-1:0] r_mcand;
    logic [MPLR_WIDTH-1:0]  r_mplr;
    logic [MCAND_WIDTH-1:0] r_acc;
    logic                   r_ovf;
    logic [MCAND_WIDTH+1:0] w_sum;

    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0}
              + {2'b00, (r_mplr[MPLR_WIDTH-1] ? r_mcand : {MCAND_WIDTH{1'b0}})};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(MPLR_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
        end else if (r_busy) begin
            r_mplr <= {r_mplr[MPLR_WIDTH-2:0], 1'b0};
            r_acc  <= w_sum[MCAND_WIDTH-1:0];
            r_ovf  <= r_ovf | (|w_sum[MCAND_WIDTH+1:MCAND_WIDTH]);
        end
    end

    assign o_busy     = r_busy;
    assign o_product  = r_acc;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

[rtl/rmv_datapath.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: datapath
// Statistics registers, the shared divider, the squarer, the serial
// multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_datapath #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmv_pkg::t_dp_cmd              i_cmd,
    output rmv_pkg::t_dp_sts              o_sts,
    input  logic [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic                          i_restart,
    output logic [SAMPLE_WIDTH-1:0]       o_mean,
    output logic [rmv_pkg::VAR_WIDTH-1:0] o_variance,
    output logic [COUNT_WIDTH-1:0]        o_count,
    output logic                          o_variance_saturated
);

    import rmv_pkg::*;

    localparam int DIV_W = (SAMPLE_WIDTH + 1 > VAR_WIDTH) ? SAMPLE_WIDTH + 1 : VAR_WIDTH;
    localparam int MAG_W = (SAMPLE_WIDTH + 1 > SQ_IN_W + 1) ? SAMPLE_WIDTH + 1 : SQ_IN_W + 1;

    logic [SAMPLE_WIDTH-1:0] r_x;
    logic [SAMPLE_WIDTH-1:0] r_mean;
    logic [SAMPLE_WIDTH-1:0] r_mean_new;
    logic [VAR_WIDTH-1:0]    r_var;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic                    r_flag;
    logic                    r_neg;
    logic [SAMPLE_WIDTH-1:0] r_qmag;
    logic                    r_big;
    logic [SQ_W-1:0]         r_sq;
    logic [SAMPLE_WIDTH-1:0] r_out_mean;
    logic [VAR_WIDTH-1:0]    r_out_var;
    logic [COUNT_WIDTH-1:0]  r_out_count;
    logic                    r_out_sat;

    logic [COUNT_WIDTH-1:0]  w_cnt_base;
    logic [COUNT_WIDTH-1:0]  w_cnt_next;
    logic [SAMPLE_WIDTH:0]   w_diff;
    logic [SAMPLE_WIDTH:0]   w_mag;
    logic [DIV_W-1:0]        w_dividend;
    logic [COUNT_WIDTH-1:0]  w_divisor;
    logic [DIV_W-1:0]        w_quo;
    logic [COUNT_WIDTH-1:0]  w_rem;
    logic                    w_div_busy;
    logic [MAG_W-1:0]        w_mag_ext;
    logic [SQ_IN_W-1:0]      w_mag_lo;
    logic [SQ_W-1:0]         w_sq;
    logic [SQ_W-1:0]         w_prod;
    logic                    w_mul_ovf;
    logic                    w_mul_busy;
    logic                    w_n_ge2;
    logic [VAR_WIDTH-1:0]    w_dec;
    logic [VAR_WIDTH-1:0]    w_scaled;
    logic [VAR_WIDTH:0]      w_sum;
    logic                    w_sat;
    logic [VAR_WIDTH-1:0]    w_var_new;
    logic                    w_flag_new;

    always_comb begin
        w_cnt_base = i_restart ? '0 : r_count;
        w_cnt_next = (&w_cnt_base) ? w_cnt_base : w_cnt_base + COUNT_WIDTH'(1);

        w_diff     = {r_x[SAMPLE_WIDTH-1], r_x} - {r_mean[SAMPLE_WIDTH-1], r_mean};
        w_mag      = w_diff[SAMPLE_WIDTH] ? -w_diff : w_diff;

        w_dividend = i_cmd.div_sel_var ? DIV_W'(r_var) : DIV_W'(w_mag);
        w_divisor  = i_cmd.div_sel_var ? r_count - COUNT_WIDTH'(1) : r_count;

        w_mag_ext  = MAG_W'(r_qmag);
        w_mag_lo   = w_mag_ext[SQ_IN_W-1:0];
        w_sq       = w_mag_lo * w_mag_lo;

        w_n_ge2    = (r_count > COUNT_WIDTH'(1));

        w_dec      = w_quo[VAR_WIDTH-1:0] + VAR_WIDTH'(|w_rem);
        w_scaled   = r_var - w_dec;
        w_sum      = {1'b0, w_scaled} + {1'b0, w_prod[SQ_W-1:VAR_FRAC]};
        w_sat      = r_big | w_mul_ovf | (w_sum >= {1'b0, VAR_MAX});

        w_var_new  = !w_n_ge2 ? '0 : (w_sat ? VAR_MAX : w_sum[VAR_WIDTH-1:0]);
        w_flag_new = r_flag | (w_n_ge2 & w_sat);
    end

    rmv_div #(
        .DIVIDEND_WIDTH (DIV_W),
        .DIVISOR_WIDTH  (COUNT_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    rmv_mul #(
        .MCAND_WIDTH (SQ_W),
        .MPLR_WIDTH  (COUNT_WIDTH)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul_start),
        .i_mcand    (r_sq),
        .i_mplr     (r_count),
        .o_busy     (w_mul_busy),
        .o_product  (w_prod),
        .o_overflow (w_mul_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_var   <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
        end else if (i_cmd.load) begin
            r_count <= w_cnt_next;
            if (i_restart) begin
                r_mean <= '0;
                r_var  <= '0;
                r_flag <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            r_mean <= r_mean_new;
            r_var  <= w_var_new;
            r_flag <= w_flag_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.div_start && !i_cmd.div_sel_var) begin
            r_neg <= w_diff[SAMPLE_WIDTH];
        end
        if (i_cmd.take_q) begin
            r_qmag     <= w_quo[SAMPLE_WIDTH-1:0];
            r_mean_new <= r_neg ? r_mean - w_quo[SAMPLE_WIDTH-1:0]
                                : r_mean + w_quo[SAMPLE_WIDTH-1:0];
        end
        if (i_cmd.square) begin
            r_big <= |w_mag_ext[MAG_W-1:SQ_IN_W];
            r_sq  <= w_sq;
        end
        if (i_cmd.commit) begin
            r_out_mean  <= r_mean_new;
            r_out_var   <= w_var_new;
            r_out_count <= r_count;
            r_out_sat   <= w_flag_new;
        end
    end

    assign o_sts.div_busy = w_div_busy;
    assign o_sts.mul_busy = w_mul_busy;
    assign o_sts.n_ge2    = w_n_ge2;

    assign o_mean               = r_out_mean;
    assign o_variance           = r_out_var;
    assign o_count              = r_out_count;
    assign o_variance_saturated = r_out_sat;

endmodule

`default_nettype wire

[rtl/rmv_ctrl.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: controller
// Sequences one sample through the divider and multiplier and manages the
// input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rmv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  rmv_pkg::t_dp_sts i_sts,
    output rmv_pkg::t_dp_cmd o_cmd
);

    import rmv_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DQ_GO   = 3'd1;
    localparam logic [2:0] S_DQ_WAIT = 3'd2;
    localparam logic [2:0] S_SQ      = 3'd3;
    localparam logic [2:0] S_MUL_GO  = 3'd4;
    localparam logic [2:0] S_V_WAIT  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DQ_GO;
                end
            end
            S_DQ_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DQ_WAIT;
            end
            S_DQ_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = i_sts.n_ge2 ? S_SQ : S_DONE;
                end
            end
            S_SQ: begin
                o_cmd.square      = 1'b1;
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_var = 1'b1;
                n_state           = S_MUL_GO;
            end
            S_MUL_GO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_V_WAIT;
            end
            S_V_WAIT: begin
                if (!i_sts.div_busy && !i_sts.mul_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/running_mean_variance.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: top level
// Recursive sample mean and unbiased sample variance of a Q16.16 stream.
//
//   Channel  Handshake                Payload
//   input    i_in_valid / o_in_stall  i_in_sample, i_in_restart
//   output   o_out_valid / i_out_stall o_out_mean, o_out_variance,
//                                      o_out_count, o_out_variance_saturated
//
// A sample that is the first since restart takes the mean division only;
// any other sample then also takes the variance division. Both run on the
// shared one-bit-per-cycle divider of DW = max(SAMPLE_WIDTH + 1, 48) bits.
// The next transaction can be taken in the cycle the result appears. The
// serial multiplier runs alongside the variance division (COUNT_WIDTH < DW).
// Reset is synchronous and clears the statistics and both handshakes.
// The next transaction is accepted while a result waits in the output
// register; a stalled output only holds the block at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]       i_in_sample,
    input  logic                          i_in_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [SAMPLE_WIDTH-1:0]       o_out_mean,
    output logic [rmv_pkg::VAR_WIDTH-1:0] o_out_variance,
    output logic [COUNT_WIDTH-1:0]        o_out_count,
    output logic                          o_out_variance_saturated
);

    import rmv_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    rmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rmv_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_sample             (i_in_sample),
        .i_restart            (i_in_restart),
        .o_mean               (o_out_mean),
        .o_variance           (o_out_variance),
        .o_count              (o_out_count),
        .o_variance_saturated (o_out_variance_saturated)
    );

endmodule

`default_nettype wire

[rtl/rmv_checker.sv]
// ----------------------------------------------------------------------------
// Running mean and variance: port checker
// Assertions on the top-level ports, bound to every instance of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_mean_variance_macros.svh"

module rmv_port_checker #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [SAMPLE_WIDTH-1:0]       o_out_mean,
    input logic [rmv_pkg::VAR_WIDTH-1:0] o_out_variance,
    input logic [COUNT_WIDTH-1:0]        o_out_count,
    input logic                          o_out_variance_saturated
);

    import rmv_pkg::*;

    localparam int OUT_W = SAMPLE_WIDTH + VAR_WIDTH + COUNT_WIDTH + 1;

    logic             w_in_take;
    logic             w_out_wait;
    logic [OUT_W-1:0] w_out_bus;
    logic             w_first;
    logic             w_var_clear;

    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_out_wait  = o_out_valid && i_out_stall;
    assign w_out_bus   = {o_out_mean, o_out_variance, o_out_count, o_out_variance_saturated};
    assign w_first     = o_out_valid && (o_out_count == COUNT_WIDTH'(1));
    assign w_var_clear = (o_out_variance == '0) && !o_out_variance_saturated;

    `RMV_ASSERT_NEXT(a_out_hold, w_out_wait, o_out_valid && $stable(w_out_bus), "stalled result moved")
    `RMV_ASSERT_NEXT(a_in_busy, w_in_take, o_in_stall, "second transaction accepted back to back")
    `RMV_ASSERT_NOW(a_first_zero, w_first, w_var_clear, "nonzero variance after first sample")
    `RMV_ASSERT_NOW(a_count_nonzero, o_out_valid, o_out_count != '0, "result with zero count")

endmodule

bind running_mean_variance rmv_port_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
) u_rmv_checker (.*);

`default_nettype wire
